// ===== design/wbps_pkg.sv =====
// Shared constants and types of the wildcard byte pattern scanner.
`timescale 1ns / 1ps

package wbps_pkg;

  // Pattern bytes held by the two pattern registers.
  localparam int unsigned REG_PATTERN_BYTES     = 16;
  localparam int unsigned DEF_MAX_PATTERN_BYTES = 16;

  // Field and register widths.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned SEEN_W     = 32;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CARE_W     = 16;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 6;

  // Register reset values.
  localparam logic [CARE_W-1:0] CARE_RESET = 16'hFFFF;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd1;

  // Register indexes, taken from paddr[5:3].
  typedef enum logic [2:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_BASE_ADDRESS = 3'd4
  } reg_idx_e;

  // Pattern settings handed to the compare unit.
  typedef struct packed {
    logic [REG_PATTERN_BYTES*BYTE_W-1:0] pattern;
    logic [CARE_W-1:0]                   care;
    logic [LEN_W-1:0]                    length;
  } pattern_cfg_t;

endpackage

// ===== design/wbps_match.sv =====
// Masked compare of the byte window against the configured pattern.
`timescale 1ns / 1ps

module wbps_match
  import wbps_pkg::*;
#(
  parameter int unsigned MaxPatternBytes = DEF_MAX_PATTERN_BYTES
) (
  input  logic [MaxPatternBytes-1:0][BYTE_W-1:0] window_i,
  input  pattern_cfg_t                           cfg_i,
  output logic                                   hit_o,
  output logic [LEN_W-1:0]                       len_o
);

  localparam int unsigned Cap  = (MaxPatternBytes < REG_PATTERN_BYTES) ?
                                 MaxPatternBytes : REG_PATTERN_BYTES;
  localparam int unsigned IdxW = (MaxPatternBytes > 1) ? $clog2(MaxPatternBytes) : 1;

  logic [LEN_W-1:0] len_eff;

  // Clamp the length into 1 .. Cap; zero counts as one.
  always_comb begin
    if (cfg_i.length == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg_i.length > LEN_W'(Cap)) begin
      len_eff = LEN_W'(Cap);
    end else begin
      len_eff = cfg_i.length;
    end
  end

  // Pattern byte i is compared with the byte that arrived len-1-i bytes ago.
  always_comb begin
    logic [LEN_W-1:0] age;
    hit_o = 1'b1;
    age   = '0;
    for (int i = 0; i < Cap; i++) begin
      age = len_eff - LEN_W'(1) - LEN_W'(i);
      if ((LEN_W'(i) < len_eff) && cfg_i.care[i]) begin
        if (window_i[age[IdxW-1:0]] != cfg_i.pattern[i*BYTE_W +: BYTE_W]) begin
          hit_o = 1'b0;
        end
      end
    end
  end

  assign len_o = len_eff;

endmodule

// ===== design/wildcard_byte_pattern_scan.sv =====
// Top level of the wildcard byte pattern scanner.
//
// The slave stream carries one memory byte per word (tdata) and marks the
// final byte of a region with tlast. The block slides the bytes through a
// window and compares it with a pattern of up to 16 bytes in which any byte
// may be a wildcard (care mask bit clear). The first complete match of a
// region gives one master word with tuser set and the matched address in
// tdata; later bytes are dropped up to tlast. A region without a match gives
// one word with tuser clear and tdata zero at its last byte.
// Registers are written over the APB port, 64-bit data at byte address 8*i.
// The word appears the cycle after its last input byte is taken. Throughput
// is one byte per cycle unless the output stalls, set by the single compare
// and address add between the window registers and the output register.
// When the receiver stalls, the output register holds its word and tready
// drops only while that register is full and not being taken.
// Reset clears the window, the byte count and the output valid flag, and
// loads the register defaults (care mask all ones, length one).
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan
  import wbps_pkg::*;
#(
  parameter int unsigned MaxPatternBytes = DEF_MAX_PATTERN_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Slave stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tlast,
  // Master stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ADDR_W-1:0]     m_axis_tdata,   // [63:0] match_address
  output logic                  m_axis_tuser,   // [0] found
  // APB configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q;
  logic [CARE_W-1:0]     care_q;
  logic [LEN_W-1:0]      len_q;
  logic [ADDR_W-1:0]     base_q;
  reg_idx_e              reg_idx;
  logic                  cfg_wr;

  // Region state.
  logic [MaxPatternBytes-1:0][BYTE_W-1:0] win_q, win_d, win_shift;
  logic [SEEN_W-1:0] seen_q, seen_d, seen_inc;
  logic              reported_q, reported_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;

  // Compare results.
  pattern_cfg_t      pcfg;
  logic              win_hit;
  logic [LEN_W-1:0]  len_eff;
  logic              take, hit;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= CARE_RESET;
      len_q    <= LEN_RESET;
      base_q   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PATTERN_LOW:  pat_lo_q <= pwdata;
        REG_PATTERN_HIGH: pat_hi_q <= pwdata;
        REG_CARE_MASK:    care_q   <= pwdata[CARE_W-1:0];
        REG_PATTERN_LEN:  len_q    <= pwdata[LEN_W-1:0];
        REG_BASE_ADDRESS: base_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LOW:  prdata = pat_lo_q;
      REG_PATTERN_HIGH: prdata = pat_hi_q;
      REG_CARE_MASK:    prdata = CFG_DATA_W'(care_q);
      REG_PATTERN_LEN:  prdata = CFG_DATA_W'(len_q);
      REG_BASE_ADDRESS: prdata = base_q;
      default:          prdata = '0;
    endcase
  end

  // The window as it stands once the incoming byte is shifted in.
  always_comb begin
    win_shift[0] = s_axis_tdata;
    for (int k = 1; k < MaxPatternBytes; k++) begin
      win_shift[k] = win_q[k-1];
    end
  end

  assign pcfg.pattern = {pat_hi_q, pat_lo_q};
  assign pcfg.care    = care_q;
  assign pcfg.length  = len_q;

  wbps_match #(
    .MaxPatternBytes(MaxPatternBytes)
  ) u_match (
    .window_i(win_shift),
    .cfg_i   (pcfg),
    .hit_o   (win_hit),
    .len_o   (len_eff)
  );

  // A word is taken whenever the output register is free or being emptied.
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign take          = s_axis_tvalid & s_axis_tready;
  assign seen_inc      = (seen_q == '1) ? seen_q : seen_q + SEEN_W'(1);
  assign hit           = win_hit && (seen_inc >= SEEN_W'(len_eff));

  // Region state and the result for the byte being taken.
  always_comb begin
    win_d       = win_q;
    seen_d      = seen_q;
    reported_d  = reported_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_found_d = out_found_q;
    out_addr_d  = out_addr_q;
    if (take) begin
      if (!reported_q) begin
        win_d  = win_shift;
        seen_d = seen_inc;
        if (hit) begin
          reported_d  = 1'b1;
          out_valid_d = 1'b1;
          out_found_d = 1'b1;
          out_addr_d  = base_q + ADDR_W'(seen_inc - SEEN_W'(len_eff));
        end else if (s_axis_tlast) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b0;
          out_addr_d  = '0;
        end
      end
      if (s_axis_tlast) begin
        win_d      = '0;
        seen_d     = '0;
        reported_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      seen_q      <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      seen_q      <= seen_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_addr_q  <= out_addr_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_found_q;

endmodule

// ===== design/wbps_checker.sv =====
// Port-level checks of the wildcard byte pattern scanner, bound to the top level.
`timescale 1ns / 1ps

module wbps_checker
  import wbps_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [ADDR_W-1:0] m_axis_tdata,
  input logic              m_axis_tuser
);

  // A stalled output word stays valid.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  // A not-found word carries a zero address.
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("not-found word with nonzero address");

  // Input stalls only while a finished word waits on the receiver.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending output word");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (.*);
